// File: sv/assert_macros.svh
// Assertion helpers used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is applied.
`define UFSK_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked property that also holds while reset is applied.
`define UFSK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/ufsk_pkg.sv
package ufsk_pkg;

  // Default geometry of the block.
  localparam int unsigned PhaseBitsDef    = 32;
  localparam int unsigned SineAddrBitsDef = 10;
  localparam int unsigned LeadinBitsDef   = 16;

  // Configuration port.
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] RegMarkStep   = 2'd0;
  localparam logic [CfgIndexW-1:0] RegSpaceStep  = 2'd1;
  localparam logic [CfgIndexW-1:0] RegBitSamples = 2'd2;

  localparam int unsigned     BitSamplesW = 16;
  localparam logic [15:0]     BitsReset   = 16'd40;

  // UART framing.
  localparam int unsigned FrameW     = 10;
  localparam logic [9:0]  IdleFrame  = 10'h3ff;
  localparam logic [3:0]  FrameShifts = 4'd9;

  // Sine amplitude and magnitude width.
  localparam int unsigned AmpW       = 15;
  localparam logic [63:0] Amplitude  = 64'd32766;
  localparam logic [63:0] TwoPiQ30   = 64'd6746518852;

  typedef struct packed {
    logic       byte_ready;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               byte_taken;
    logic               line_bit;
  } out_word_t;

  // Truncating unsigned quotient by shift and subtract. Used only while the
  // sine table is built at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine magnitude for index k of a 2^addr_bits table, built from
  // a truncated Q30 Taylor series. Evaluated at elaboration only.
  function automatic logic [AmpW-1:0] sine_entry(input int unsigned k,
                                                 input int unsigned addr_bits);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] div;
    longint      s;
    int unsigned n;
    th = (64'(k) * TwoPiQ30 + (64'd1 << (addr_bits - 1))) >> addr_bits;
    th2 = (th * th) >> 30;
    t = th;
    s = longint'(th);
    for (n = 1; n <= 12; n++) begin
      if (t != 64'd0) begin
        div = 64'((2 * n) * (2 * n + 1));
        t = udiv64((t * th2) >> 30, div);
        if (n[0]) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
    end
    if (s < 0) begin
      s = 0;
    end
    v = (64'(s) * Amplitude + (64'd1 << 29)) >> 30;
    if (v > Amplitude) begin
      v = Amplitude;
    end
    return v[AmpW-1:0];
  endfunction

endpackage

// File: sv/uart_fsk_modulator.sv
// Phase-continuous binary FSK modulator with UART framing.
// Every word on the input channel (in_valid_i / in_stall_o / in_data_i) is one
// sample tick and carries an optional data byte. Every tick yields exactly one
// word on the output channel (out_valid_o / out_stall_i / out_data_o): a signed
// sine sample, a flag that the offered byte was consumed, and the line bit.
// Bytes go out as 10-bit frames (start bit, eight data bits LSB first, stop
// bit), each bit lasting bit_samples ticks; with no byte at a frame boundary an
// all-ones idle frame is sent. Line bit 1 advances the phase by mark_step and
// line bit 0 by space_step.
// An accepted word passes through the middle stage and the output register;
// one word is accepted every cycle unless in_stall_o is high. The framing
// counters and the phase add are resolved at acceptance, the table lookup in the middle stage.
// Reset clears the phase, loads both steps with zero, bit_samples with 40, and
// starts a lead-in of LEADIN_BITS bit periods of mark tone. When the receiver
// stalls, the output word holds, the middle stage fills, and then in_stall_o
// rises in the same cycle; no word is lost.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at the
// clock edge and are meant for idle periods only.
module uart_fsk_modulator #(
  parameter int unsigned PHASE_BITS     = ufsk_pkg::PhaseBitsDef,
  parameter int unsigned SINE_ADDR_BITS = ufsk_pkg::SineAddrBitsDef,
  parameter int unsigned LEADIN_BITS    = ufsk_pkg::LeadinBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ufsk_pkg::in_word_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ufsk_pkg::out_word_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [ufsk_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ufsk_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import ufsk_pkg::*;

  // The countdown must hold LEADIN_BITS full bit periods of the longest bit.
  localparam int unsigned CntW = BitSamplesW + $clog2(LEADIN_BITS + 1);
  localparam logic [CntW-1:0] CntReset = CntW'(LEADIN_BITS) * CntW'(BitsReset);

  // Configuration registers.
  logic [PHASE_BITS-1:0]  mark_step_q;
  logic [PHASE_BITS-1:0]  space_step_q;
  logic [BitSamplesW-1:0] bit_samples_q;

  // Modulator state.
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [CntW-1:0]       countdown_q, countdown_d;
  logic [3:0]            bits_left_q, bits_left_d;
  logic [FrameW-1:0]     frame_q, frame_d;
  logic                  leadin_q, leadin_d;

  // Middle stage: table address plus the flags that travel with it.
  logic                      s1_valid_q;
  logic [SINE_ADDR_BITS-1:0] s1_addr_q;
  logic                      s1_taken_q;
  logic                      s1_bit_q;

  // Output register.
  logic      out_valid_q;
  out_word_t out_data_q;

  logic                      out_load;
  logic                      in_accept;
  logic                      taken;
  logic [CntW-1:0]           cnt_base;
  logic [BitSamplesW-1:0]    eff_samples;
  logic [BitSamplesW-1:0]    cfg_samples;
  logic signed [15:0]        rom_value;

  // The output register takes a new word when it is empty or being drained;
  // the middle stage always empties into it at that moment.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // A programmed bit length of zero behaves as one tick.
  assign eff_samples = (bit_samples_q == '0) ? BitSamplesW'(1) : bit_samples_q;
  assign cfg_samples = (cfg_wdata_i[BitSamplesW-1:0] == '0) ? BitSamplesW'(1)
                                                            : cfg_wdata_i[BitSamplesW-1:0];

  // One tick of the UART framer and phase accumulator.
  always_comb begin
    frame_d     = frame_q;
    bits_left_d = bits_left_q;
    leadin_d    = leadin_q;
    taken       = 1'b0;
    cnt_base    = countdown_q;
    if (countdown_q == '0) begin
      cnt_base = CntW'(eff_samples);
      leadin_d = 1'b0;
      if (bits_left_q == '0) begin
        bits_left_d = FrameShifts;
        if (in_data_i.byte_ready) begin
          // Start bit low in bit 0, stop bit high on top.
          frame_d = {1'b1, in_data_i.byte_value, 1'b0};
          taken   = 1'b1;
        end else begin
          frame_d = IdleFrame;
        end
      end else begin
        frame_d     = frame_q >> 1;
        bits_left_d = bits_left_q - 4'd1;
      end
    end
    countdown_d = cnt_base - CntW'(1);
    phase_d     = phase_q + (frame_d[0] ? mark_step_q : space_step_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_step_q   <= '0;
      space_step_q  <= '0;
      bit_samples_q <= BitsReset;
      phase_q       <= '0;
      countdown_q   <= CntReset;
      bits_left_q   <= '0;
      frame_q       <= FrameW'(1);
      leadin_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMarkStep: begin
          mark_step_q <= cfg_wdata_i[PHASE_BITS-1:0];
        end
        RegSpaceStep: begin
          space_step_q <= cfg_wdata_i[PHASE_BITS-1:0];
        end
        RegBitSamples: begin
          bit_samples_q <= cfg_wdata_i[BitSamplesW-1:0];
          // A new bit length during the lead-in restarts the lead-in.
          if (leadin_q) begin
            countdown_q <= CntW'(LEADIN_BITS) * CntW'(cfg_samples);
          end
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      phase_q     <= phase_d;
      countdown_q <= countdown_d;
      bits_left_q <= bits_left_d;
      frame_q     <= frame_d;
      leadin_q    <= leadin_d;
    end
  end

  // Middle stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_addr_q  <= phase_d[PHASE_BITS-1 -: SINE_ADDR_BITS];
      s1_taken_q <= taken;
      s1_bit_q   <= frame_d[0];
    end
  end

  ufsk_sine_rom #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_sine_rom (
    .addr_i (s1_addr_q),
    .value_o(rom_value)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_data_q.sample     <= rom_value;
      out_data_q.byte_taken <= s1_taken_q;
      out_data_q.line_bit   <= s1_bit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/ufsk_sine_rom.sv
module ufsk_sine_rom #(
  parameter int unsigned SINE_ADDR_BITS = ufsk_pkg::SineAddrBitsDef
) (
  input  logic [SINE_ADDR_BITS-1:0] addr_i,
  output logic signed [15:0]        value_o
);
  import ufsk_pkg::*;

  localparam int unsigned Quarter = 1 << (SINE_ADDR_BITS - 2);
  localparam int unsigned IdxW    = SINE_ADDR_BITS - 1;

  logic [AmpW-1:0] quarter_rom [Quarter+1];

  for (genvar k = 0; k <= Quarter; k++) begin : g_rom
    localparam logic [AmpW-1:0] Entry = sine_entry(k, SINE_ADDR_BITS);
    assign quarter_rom[k] = Entry;
  end

  logic [1:0]            quad;
  logic [SINE_ADDR_BITS-3:0] rem;
  logic [IdxW-1:0]       idx;
  logic [AmpW-1:0]       mag;

  assign quad = addr_i[SINE_ADDR_BITS-1 -: 2];
  assign rem  = addr_i[SINE_ADDR_BITS-3:0];

  // Odd quadrants run the quarter wave backwards, the second half of the turn is negated.
  always_comb begin
    if (quad[0]) begin
      idx = IdxW'(Quarter) - IdxW'(rem);
    end else begin
      idx = IdxW'(rem);
    end
    mag = quarter_rom[idx];
    if (quad[1]) begin
      value_o = -$signed({1'b0, mag});
    end else begin
      value_o = $signed({1'b0, mag});
    end
  end

endmodule

// File: sv/ufsk_checker.sv
`include "assert_macros.svh"

module ufsk_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ufsk_pkg::out_word_t out_data_o
);
  import ufsk_pkg::*;

  // A stalled result word stays put until it is taken.
  `UFSK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled output word changed")

  // With the output register empty the pipeline always has room.
  `UFSK_ASSERT(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o |-> !in_stall_o, "input stalled while output empty")

  // A byte is consumed only as its frame starts, which is the low start bit.
  `UFSK_ASSERT(a_taken_start_bit, clk_i, rst_ni, out_valid_o && out_data_o.byte_taken |-> !out_data_o.line_bit, "byte taken outside a start bit")

  // Samples stay inside the scaled sine range.
  `UFSK_ASSERT(a_sample_range, clk_i, rst_ni, out_valid_o |-> ($signed(out_data_o.sample) <= 16'sd32766 && $signed(out_data_o.sample) >= -16'sd32766), "sample out of range")

  // Nothing is presented while reset is held.
  `UFSK_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind uart_fsk_modulator ufsk_checker u_ufsk_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// File: tb/uart_fsk_modulator_tb.sv
module uart_fsk_modulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ufsk_pkg::*;

  // The index one above the last register does not exist. Writes to it must be
  // dropped without touching any of the three real registers.
  localparam logic [CfgIndexW-1:0] RegUnused = 2'd3;

  // Geometry of the sine table and of the lead-in, matching the defaults of the block.
  localparam int unsigned AddrBits    = 10;
  localparam int unsigned TableSize   = 1 << AddrBits;
  localparam int unsigned QuarterSize = TableSize >> 2;
  localparam int unsigned LeadinBits  = 16;
  localparam longint unsigned SineAmp = 64'd32766;
  localparam longint unsigned AngleTurnQ30 = 64'd6746518852;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;

  uart_fsk_modulator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Tick words waiting to be offered, and the output words that the accepted
  // ticks must produce, oldest first.
  in_word_t  ticks_to_send[$];
  out_word_t predicted_outputs[$];

  int unsigned mismatch_count = 0;
  int unsigned words_seen = 0;

  // Shadow copy of the configuration registers, with their reset values.
  logic [31:0] mark_incr = '0;
  logic [31:0] space_incr = '0;
  logic [15:0] bit_len_shadow = BitsReset;

  // Shadow copy of the modulator state. The lead-in counts down sixteen bit
  // periods of mark tone before the first frame boundary.
  logic [31:0] phase_acc = '0;
  logic [19:0] ticks_left_in_bit = 20'(LeadinBits) * 20'd40;
  logic [3:0]  shifts_left = '0;
  logic [9:0]  frame_bits = 10'd1;
  logic        in_leadin = 1'b1;

  // Quarter-wave magnitudes, indexes 0 through QuarterSize inclusive.
  logic [14:0] wave_mag [0:QuarterSize];

  // One magnitude of the quarter wave. The angle is rounded to Q30 radians, the
  // sine is summed from its Taylor series with truncating products and
  // divisions, and the result is scaled to the amplitude with half-up rounding.
  function automatic logic [14:0] quarter_mag(input int unsigned k);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned mag;
    longint          acc;
    int unsigned     n;
    angle = (64'(k) * AngleTurnQ30 + 64'(TableSize / 2)) / 64'(TableSize);
    angle_sq = (angle * angle) >> 30;
    term = angle;
    acc = longint'(angle);
    for (n = 1; n <= 12; n++) begin
      if (term != 0) begin
        term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    mag = (64'(acc) * SineAmp + (64'd1 << 29)) >> 30;
    if (mag > SineAmp) begin
      mag = SineAmp;
    end
    return mag[14:0];
  endfunction

  initial begin : fill_wave
    int unsigned k;
    for (k = 0; k <= QuarterSize; k++) begin
      wave_mag[k] = quarter_mag(k);
    end
  end

  // The full wave follows from the quarter wave: odd quadrants run the table
  // backward, the second half of the turn flips the sign.
  function automatic logic signed [15:0] tone_sample(input logic [AddrBits-1:0] addr);
    logic [1:0]         quad;
    logic [8:0]         idx;
    logic signed [15:0] mag;
    quad = addr[AddrBits-1 -: 2];
    idx = quad[0] ? (9'(QuarterSize) - 9'(addr[AddrBits-3:0])) : 9'(addr[AddrBits-3:0]);
    mag = 16'(wave_mag[idx]);
    return quad[1] ? -mag : mag;
  endfunction

  // Advances the shadow state by one accepted tick and queues the output word
  // that the tick must produce. At the end of a bit the countdown reloads; at a
  // frame boundary a new frame starts, holding the offered byte if there is
  // one and the all-ones idle pattern if not. A byte offered anywhere else is
  // not consumed.
  function automatic void predict_sample(input in_word_t tick);
    out_word_t   word;
    logic [15:0] period;
    period = (bit_len_shadow == '0) ? 16'd1 : bit_len_shadow;
    word.byte_taken = 1'b0;
    if (ticks_left_in_bit == '0) begin
      ticks_left_in_bit = 20'(period);
      in_leadin = 1'b0;
      if (shifts_left == '0) begin
        shifts_left = FrameShifts;
        if (tick.byte_ready) begin
          frame_bits = {1'b1, tick.byte_value, 1'b0};
          word.byte_taken = 1'b1;
        end else begin
          frame_bits = IdleFrame;
        end
      end else begin
        frame_bits = frame_bits >> 1;
        shifts_left = shifts_left - 4'd1;
      end
    end
    ticks_left_in_bit = ticks_left_in_bit - 20'd1;
    word.line_bit = frame_bits[0];
    phase_acc = phase_acc + (frame_bits[0] ? mark_incr : space_incr);
    word.sample = tone_sample(phase_acc[31 -: AddrBits]);
    predicted_outputs.push_back(word);
  endfunction

  // One printed line per mismatch, and the count goes up.
  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Length of the next idle stretch, mostly none, sometimes short and rarely a
  // long one. Now and then a calm stretch with no idling at all starts.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Sender. A word stays on the bus until it is taken; the shadow state
  // advances on the edge that takes it. After each word the sender may idle.
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;

  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_sample(in_data_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (ticks_to_send.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= ticks_to_send.pop_front();
          tx_gap = idle_len(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern. Once, well into the run, the receiver holds off
  // for a long stretch while the sender keeps offering, so the block fills up
  // and has to stall its input.
  int unsigned rx_wait = 0;
  int unsigned rx_calm = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk_i) begin : receiver_stall
    if (rst_ni) begin
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_stall_i <= 1'b1;
      end else if (!long_hold_done && words_seen >= 120) begin
        long_hold_done = 1'b1;
        long_hold_left = 80;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        rx_wait = idle_len(rx_calm);
      end
    end
  end

  // Output checker: every word taken is held against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (predicted_outputs.size() == 0) begin
        flag_mismatch($sformatf("output word %h with nothing predicted", out_data_o));
      end else begin
        want = predicted_outputs.pop_front();
        if (out_data_o.sample !== want.sample) begin
          flag_mismatch($sformatf("word %0d sample %0d, expected %0d", words_seen,
                                  out_data_o.sample, want.sample));
        end
        if (out_data_o.byte_taken !== want.byte_taken) begin
          flag_mismatch($sformatf("word %0d byte_taken %b, expected %b", words_seen,
                                  out_data_o.byte_taken, want.byte_taken));
        end
        if (out_data_o.line_bit !== want.line_bit) begin
          flag_mismatch($sformatf("word %0d line_bit %b, expected %b", words_seen,
                                  out_data_o.line_bit, want.line_bit));
        end
      end
    end
  end

  // Drives one register write, which lands on the next edge, and mirrors it in
  // the shadow registers. The caller lowers the write enable after the last one.
  // A new bit period written during the lead-in restarts the lead-in.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      RegMarkStep: begin
        mark_incr = value;
      end
      RegSpaceStep: begin
        space_incr = value;
      end
      RegBitSamples: begin
        bit_len_shadow = value[15:0];
        if (in_leadin) begin
          ticks_left_in_bit = 20'(LeadinBits) *
                              ((value[15:0] == '0) ? 20'd1 : 20'(value[15:0]));
        end
      end
      default: begin
      end
    endcase
  endtask

  // Writes all three registers plus the nonexistent one. The upper half of the
  // bit period write carries random bits that the block must drop.
  task automatic configure(input logic [31:0] mark, input logic [31:0] space,
                           input logic [15:0] period);
    write_reg(RegMarkStep, mark);
    write_reg(RegSpaceStep, space);
    write_reg(RegBitSamples, {16'($urandom), period});
    write_reg(RegUnused, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // Random ticks in stretches: busy stretches offer a byte on most ticks,
  // quiet ones rarely, so both data frames and idle frames go out.
  task automatic queue_random_ticks(input int unsigned count);
    in_word_t    tick;
    int unsigned i;
    bit          busy;
    busy = 1'b1;
    for (i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        busy = ($urandom_range(0, 3) != 0);
      end
      tick.byte_ready = busy ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) == 0);
      tick.byte_value = 8'($urandom);
      ticks_to_send.push_back(tick);
    end
  endtask

  // Waits until every tick has gone in and every predicted word has come out,
  // then lets the clock run on so the pipeline is certainly empty.
  task automatic drain();
    while (ticks_to_send.size() != 0 || in_valid_i || predicted_outputs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  initial begin : stimulus
    in_word_t    tick;
    logic [7:0]  edge_bytes [0:5];
    int unsigned i;
    rst_ni <= 1'b0;
    edge_bytes[0] = 8'h00;
    edge_bytes[1] = 8'hff;
    edge_bytes[2] = 8'h80;
    edge_bytes[3] = 8'h01;
    edge_bytes[4] = 8'h55;
    edge_bytes[5] = 8'haa;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A quarter-turn mark step lands exactly on the quadrant
    // boundaries of the table, the space step is the largest one, and a zero
    // bit period (taken as one tick) written during the lead-in shortens it
    // to sixteen ticks. A byte is offered on every tick, so most of them fall
    // inside the lead-in or mid-frame and must be ignored.
    configure(32'h4000_0000, 32'hffff_ffff, 16'd0);
    for (i = 0; i < 24; i++) begin
      tick.byte_ready = 1'b1;
      tick.byte_value = edge_bytes[i % 6];
      ticks_to_send.push_back(tick);
    end
    drain();

    // Random phases through several bit periods and tone steps. The long
    // receiver hold falls into the first of them. Between phases the sender
    // pauses until every word is back.
    configure($urandom, $urandom, 16'd1);
    queue_random_ticks(140);
    drain();

    configure($urandom, $urandom, 16'd3);
    queue_random_ticks(140);
    drain();

    configure(32'h0000_0000, 32'hffff_ffff, 16'd2);
    queue_random_ticks(140);
    drain();

    // Longest bit period last: once it is loaded, the countdown stays within
    // one bit for the rest of the run.
    configure(32'h0123_4567, $urandom, 16'hffff);
    queue_random_ticks(40);
    drain();

    if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
      $display("uart_fsk_modulator: match");
    end else begin
      $display("uart_fsk_modulator: mismatch");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("uart_fsk_modulator: mismatch");
    $finish;
  end

endmodule
